// ===== hw/rtl/hlcm_pkg.sv =====
// Shared types and constants for the hyperperiod LCM accumulator.
// Holds the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package hlcm_pkg;

    // Width of the accumulator and of the hyperperiod result.
    localparam int unsigned ACC_W = 63;
    // Width of the task period field on the input channel.
    localparam int unsigned IN_PERIOD_W = 32;
    // Step counter: holds up to ACC_W steps of division or multiply.
    localparam int unsigned CNT_W = 6;
    // Count of common factors of two taken out during the gcd.
    localparam int unsigned K_W = 6;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1);

    // Commands from the controller; at most one is high in a cycle.
    typedef struct packed {
        logic load;
        logic set_zero;
        logic gcd_step;
        logic gcd_finish;
        logic div_step;
        logic mul_init;
        logic mul_step;
        logic commit;
        logic publish;
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic zero_case;
        logic gcd_done;
        logic div_last;
        logic mul_last;
        logic out_free;
    } t_status;

endpackage : hlcm_pkg

`default_nettype wire

// ===== hw/rtl/hlcm_ctrl.sv =====
// Sequencer for the hyperperiod LCM accumulator.
// Steps one beat through check, gcd, division, multiply and commit.
// Depends on hlcm_pkg.
`default_nettype none

module hlcm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire hlcm_pkg::t_status i_status,
    output hlcm_pkg::t_cmd       o_cmd,
    output logic                 o_in_stall
);
    import hlcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GCD,
        S_DIV,
        S_MSET,
        S_MUL,
        S_COMMIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.zero_case) begin
                    o_cmd.set_zero = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.gcd_finish = 1'b1;
                    n_state          = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MSET;
                end
            end
            S_MSET: begin
                o_cmd.mul_init = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Take a beat only between items.
    assign o_in_stall = (r_state != S_IDLE);

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("hlcm_ctrl: more than one command at once");

    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_in_stall)
        else $error("hlcm_ctrl: still taking beats after a load");

    a_publish_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> !o_in_stall)
        else $error("hlcm_ctrl: not idle after publishing a result");

endmodule : hlcm_ctrl

`default_nettype wire

// ===== hw/rtl/hlcm_datapath.sv =====
// Datapath of the hyperperiod LCM accumulator: binary gcd, restoring
// divider, MSB-first multiplier with saturation, and the output register.
// Depends on hlcm_pkg.
`default_nettype none

module hlcm_datapath #(
    parameter int unsigned PERIOD_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire hlcm_pkg::t_cmd          i_cmd,
    input  wire logic [PERIOD_WIDTH-1:0] i_period,
    input  wire logic                    i_new_set,
    input  wire logic                    i_out_stall,
    output hlcm_pkg::t_status            o_status,
    output logic                         o_out_valid,
    output logic [hlcm_pkg::ACC_W-1:0]   o_hyperperiod,
    output logic                         o_overflowed
);
    import hlcm_pkg::*;

    localparam int unsigned SUM_W = ACC_W + 2;

    // Set state: reset sets the accumulator to 1 and clears the flags.
    logic [ACC_W-1:0] r_acc;
    logic             r_ovf;
    logic             r_out_valid;

    // Working registers.
    logic [ACC_W-1:0]        r_a;
    logic [ACC_W-1:0]        r_b;
    logic [K_W-1:0]          r_k;
    logic [ACC_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic [PERIOD_WIDTH-1:0] r_p;
    logic [ACC_W-1:0]        r_prod;
    logic                    r_movf;
    logic [ACC_W-1:0]        r_out_hp;
    logic                    r_out_ovf;

    logic [ACC_W-1:0] acc_start;
    logic [ACC_W:0]   rem_sh;
    logic [ACC_W:0]   rem_diff;
    logic             rem_ge;
    logic [SUM_W-1:0] mul_sum;
    logic             mul_bit;

    assign acc_start = i_new_set ? ACC_ONE : r_acc;

    assign rem_sh   = {r_rem, r_a[ACC_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_b});
    assign rem_diff = rem_sh - {1'b0, r_b};

    assign mul_bit = r_p[PERIOD_WIDTH-1];
    assign mul_sum = {1'b0, r_prod, 1'b0} + (mul_bit ? {2'b00, r_a} : SUM_W'(0));

    always_comb begin
        o_status.zero_case = (r_a == '0) || (r_b == '0);
        o_status.gcd_done  = (r_a == '0) || (r_b == '0);
        o_status.div_last  = (r_cnt == CNT_W'(ACC_W - 1));
        o_status.mul_last  = (r_cnt == CNT_W'(PERIOD_WIDTH - 1));
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    // Set state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= ACC_ONE;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_new_set) begin
                r_acc <= ACC_ONE;
                r_ovf <= 1'b0;
            end else if (i_cmd.set_zero) begin
                r_acc <= '0;
            end else if (i_cmd.commit) begin
                r_acc <= r_movf ? ACC_MAX : r_prod;
                r_ovf <= r_ovf | r_movf;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= acc_start;
            r_b <= ACC_W'(i_period);
            r_p <= i_period;
            r_k <= '0;
        end
        if (i_cmd.gcd_step) begin
            priority if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + K_W'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
        if (i_cmd.gcd_finish) begin
            // Restore the common twos; divide the accumulator next.
            r_b   <= (r_a | r_b) << r_k;
            r_a   <= r_acc;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
            r_a   <= {r_a[ACC_W-2:0], rem_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.mul_init) begin
            r_prod <= '0;
            r_movf <= 1'b0;
            r_cnt  <= '0;
        end
        if (i_cmd.mul_step) begin
            r_p   <= r_p << 1;
            r_cnt <= r_cnt + CNT_W'(1);
            if (!r_movf) begin
                if (mul_sum[SUM_W-1:ACC_W] != 2'b00) begin
                    r_movf <= 1'b1;
                end else begin
                    r_prod <= mul_sum[ACC_W-1:0];
                end
            end
        end
        if (i_cmd.publish) begin
            r_out_hp  <= r_acc;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hyperperiod = r_out_hp;
    assign o_overflowed  = r_out_ovf;

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gcd_finish |=> (r_b != '0))
        else $error("hlcm_datapath: gcd came out zero");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem < r_b))
        else $error("hlcm_datapath: remainder not below divisor");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !i_cmd.load) |=> r_ovf)
        else $error("hlcm_datapath: overflow flag dropped within a set");

    a_sat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_movf) |=> (r_acc == ACC_MAX))
        else $error("hlcm_datapath: overflow did not saturate");

endmodule : hlcm_datapath

`default_nettype wire

// ===== hw/rtl/hyperperiod_lcm_accumulator_unit.sv =====
// Top level of the hyperperiod LCM accumulator.
// Joins the hlcm_ctrl sequencer and the hlcm_datapath; depends on hlcm_pkg.
`default_nettype none

// Keeps the running hyperperiod (least common multiple) of the task periods
// of the current set. Each input beat carries one period; its low
// PERIOD_WIDTH bits are used. new_set restarts the set at 1 and clears the
// overflow flag before the period is applied. Every input beat gives exactly
// one output beat: the updated hyperperiod and the sticky overflow flag. A
// zero period forces the hyperperiod to 0 for the rest of the set. When the
// lcm passes 2^63 - 1 the hyperperiod saturates there and overflowed is set
// until the next new_set. One beat is worked on at a time: the input is
// stalled from acceptance until the result moves into the output register,
// which then waits for the sink while the next beat is taken. A zero period
// (or a zeroed set) goes from the check straight to the output register.
// Otherwise an item runs G binary-gcd steps on 63-bit subtraction (from
// 1 up to about 2 * (63 + PERIOD_WIDTH)), 63 steps of the restoring divider
// for acc / gcd, and one multiply step per period bit. The 63-step divider
// and the bit-serial multiplier set the lower bound on the work per item.
// A stalled output register adds the time the sink holds it full.
module hyperperiod_lcm_accumulator_unit #(
    parameter int unsigned PERIOD_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [hlcm_pkg::IN_PERIOD_W-1:0]    i_task_period,
    input  wire logic                                i_new_set,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [hlcm_pkg::ACC_W-1:0]               o_hyperperiod,
    output logic                                     o_overflowed
);
    import hlcm_pkg::*;

    // Bits of the input field that reach the period register.
    localparam int unsigned USE_W = (PERIOD_WIDTH < IN_PERIOD_W) ? PERIOD_WIDTH
                                                                : IN_PERIOD_W;

    t_cmd                    cmd;
    t_status                 status;
    logic [PERIOD_WIDTH-1:0] period;

    // Drop the period bits above PERIOD_WIDTH.
    assign period = PERIOD_WIDTH'(i_task_period[USE_W-1:0]);

    hlcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    hlcm_datapath #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_period      (period),
        .i_new_set     (i_new_set),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_hyperperiod (o_hyperperiod),
        .o_overflowed  (o_overflowed)
    );

endmodule : hyperperiod_lcm_accumulator_unit

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hyperperiod_lcm_accumulator_unit: a running LCM
// predictor checks every output beat. Depends on hlcm_pkg and the unit's RTL.

module tb_top;
    import hlcm_pkg::*;

    localparam int unsigned PERIOD_W      = 32;
    localparam bit [63:0]   PERIOD_MASK   = (64'd1 << PERIOD_W) - 64'd1;
    localparam bit [63:0]   LCM_SAT       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          TARGET_BEATS  = 650;
    // Drop all idling on both sides for the last stretch of the run.
    localparam int          QUIET_BEATS   = 100;
    // Long receiver hold-off, so the unit fills up and stalls its input.
    localparam int          LONG_HOLD     = 400;
    localparam int          HOLD_AFTER    = 30;
    // Settle time after the last result; more than the worst item needs.
    localparam int          TAIL_CYCLES   = 400;
    localparam int          WATCHDOG_MAX  = 5000;

    typedef struct packed {
        logic [IN_PERIOD_W-1:0] period;
        logic                   new_set;
    } period_beat_t;

    typedef struct packed {
        logic [ACC_W-1:0] hyperperiod;
        logic             overflowed;
    } lcm_result_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // Unit inputs, all known from time zero.
    logic                   in_valid    = 1'b0;
    logic [IN_PERIOD_W-1:0] task_period = '0;
    logic                   new_set     = 1'b0;
    logic                   out_stall   = 1'b0;

    // Unit outputs.
    logic                   in_stall;
    logic                   out_valid;
    logic [ACC_W-1:0]       hyperperiod;
    logic                   overflowed;

    hyperperiod_lcm_accumulator_unit #(
        .PERIOD_WIDTH (PERIOD_W)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_task_period (task_period),
        .i_new_set     (new_set),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_hyperperiod (hyperperiod),
        .o_overflowed  (overflowed)
    );

    // Beats waiting to be driven, and results waiting to come out.
    period_beat_t period_beats_q[$];
    lcm_result_t  hyperperiod_exp_q[$];

    // Shadow of the unit's running hyperperiod and sticky overflow flag.
    bit [63:0] acc_shadow = 64'd1;
    bit        sat_shadow = 1'b0;

    int total_beats   = 0;
    int n_sent        = 0;
    int n_in_done     = 0;
    int n_out_seen    = 0;
    int n_mismatch    = 0;
    int idle_cycles   = 0;
    bit in_beat_taken = 1'b0;

    // Fold one period into the shadow LCM and return what the unit must emit.
    // gcd is found by repeated modulo; saturate when (acc / gcd) * p would
    // pass 2^63 - 1.
    task automatic fold_period_into_lcm(input period_beat_t beat, output lcm_result_t res);
        bit [63:0] p;
        bit [63:0] acc;
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] q;
        p = 64'(beat.period) & PERIOD_MASK;
        if (beat.new_set) begin
            acc_shadow = 64'd1;
            sat_shadow = 1'b0;
        end
        acc = acc_shadow;
        // A zero period, or a set already zeroed, pins the hyperperiod at 0.
        if (p == 64'd0 || acc == 64'd0) begin
            acc = 64'd0;
        end else begin
            x = acc;
            y = p;
            while (x != 64'd0 && y != 64'd0) begin
                if (x > y) begin
                    x = x % y;
                end else begin
                    y = y % x;
                end
            end
            q = acc / (x + y);
            if (q > LCM_SAT / p) begin
                acc        = LCM_SAT;
                sat_shadow = 1'b1;
            end else begin
                acc = q * p;
            end
        end
        acc_shadow      = acc & LCM_SAT;
        res.hyperperiod = acc_shadow[ACC_W-1:0];
        res.overflowed  = sat_shadow;
    endtask

    task automatic queue_beat(input logic [IN_PERIOD_W-1:0] period, input logic restart);
        period_beat_t beat;
        beat.period  = period;
        beat.new_set = restart;
        period_beats_q.push_back(beat);
    endtask

    // ------------------------------------------------------------------
    // Driver: present one beat at a time at the falling edge. Hold the
    // payload while it is not taken; idle in bursts between beats.
    // ------------------------------------------------------------------
    int  send_gap_left = 0;
    int  send_idle_pct = 30;
    bit  send_in_gap   = 1'b0;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_beat_taken) begin
            if (send_gap_left != 0) begin
                // Inside a burst of idle cycles.
                send_gap_left = send_gap_left - 1;
                in_valid <= 1'b0;
            end else if (period_beats_q.size() == 0) begin
                in_valid <= 1'b0;
            end else if (n_sent < total_beats - QUIET_BEATS &&
                         $urandom_range(99) < send_idle_pct) begin
                // Start a burst, or chain another one to stretch the gap so it
                // lands at a different point of the unit's work.
                if (!send_in_gap || $urandom_range(99) < 60) begin
                    send_gap_left = $urandom_range(2, 0);
                    send_in_gap   = 1'b1;
                    in_valid <= 1'b0;
                end else begin
                    send_in_gap = 1'b0;
                    task_period <= period_beats_q[0].period;
                    new_set     <= period_beats_q[0].new_set;
                    void'(period_beats_q.pop_front());
                    in_valid    <= 1'b1;
                    n_sent = n_sent + 1;
                end
            end else begin
                send_in_gap = 1'b0;
                task_period <= period_beats_q[0].period;
                new_set     <= period_beats_q[0].new_set;
                void'(period_beats_q.pop_front());
                in_valid    <= 1'b1;
                n_sent = n_sent + 1;
                // Change the idle mix now and then, including stretches with none.
                if (n_sent % 50 == 0) begin
                    case ($urandom_range(2))
                        0:       send_idle_pct = 0;
                        1:       send_idle_pct = 30;
                        default: send_idle_pct = 70;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in short random bursts, plus one long hold-off.
    // ------------------------------------------------------------------
    int  recv_stall_left = 0;
    int  recv_hold_left  = 0;
    bit  recv_hold_done  = 1'b0;
    int  recv_idle_pct   = 20;
    int  recv_cycle      = 0;

    always @(negedge clk) begin
        recv_cycle = recv_cycle + 1;
        if (recv_cycle % 200 == 0) begin
            case ($urandom_range(2))
                0:       recv_idle_pct = 0;
                1:       recv_idle_pct = 15;
                default: recv_idle_pct = 40;
            endcase
        end
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (recv_hold_left != 0) begin
            recv_hold_left = recv_hold_left - 1;
            out_stall <= 1'b1;
        end else if (!recv_hold_done && n_out_seen >= HOLD_AFTER) begin
            // Hold the output register full while the sender keeps offering.
            recv_hold_done = 1'b1;
            recv_hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (recv_stall_left != 0) begin
            recv_stall_left = recv_stall_left - 1;
            out_stall <= 1'b1;
        end else if (n_out_seen < total_beats - QUIET_BEATS &&
                     $urandom_range(99) < recv_idle_pct) begin
            recv_stall_left = $urandom_range(2, 0);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, predict each accepted input beat, then
    // check each accepted output beat against the oldest prediction.
    // Also run the watchdog on cycles with no beat moving.
    // ------------------------------------------------------------------
    period_beat_t mon_beat;
    lcm_result_t  mon_want;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_beat_taken <= 1'b0;
        end else begin
            in_beat_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                mon_beat.period  = task_period;
                mon_beat.new_set = new_set;
                fold_period_into_lcm(mon_beat, mon_want);
                hyperperiod_exp_q.push_back(mon_want);
                n_in_done = n_in_done + 1;
            end
            if (out_valid && !out_stall) begin
                n_out_seen = n_out_seen + 1;
                if (hyperperiod_exp_q.size() == 0) begin
                    n_mismatch = n_mismatch + 1;
                    $display("%0t: unexpected output beat, hyperperiod %0d overflowed %0b",
                             $time, hyperperiod, overflowed);
                end else begin
                    mon_want = hyperperiod_exp_q.pop_front();
                    if (hyperperiod !== mon_want.hyperperiod) begin
                        n_mismatch = n_mismatch + 1;
                        $display("%0t: hyperperiod expected %0d actual %0d",
                                 $time, mon_want.hyperperiod, hyperperiod);
                    end
                    if (overflowed !== mon_want.overflowed) begin
                        n_mismatch = n_mismatch + 1;
                        $display("%0t: overflowed expected %0b actual %0b",
                                 $time, mon_want.overflowed, overflowed);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_MAX);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        bit [63:0] smooth;
        bit [63:0] factor;
        int        set_len;
        int        kind;
        bit        restart;

        // Directed: field extremes, zero period and zeroed set, overflow and
        // saturation, restart with and without a zero period.
        queue_beat(32'd1, 1'b1);
        queue_beat(32'hFFFF_FFFF, 1'b0);
        queue_beat(32'hFFFF_FFFE, 1'b0);       // coprime pair: overflows
        queue_beat(32'd12345, 1'b0);           // stays saturated
        queue_beat(32'hFFFF_FFFB, 1'b0);
        queue_beat(32'd0, 1'b0);               // zero keeps the sticky flag
        queue_beat(32'd7, 1'b0);               // zeroed set stays zero
        queue_beat(32'd0, 1'b1);               // restart straight into zero
        queue_beat(32'd5, 1'b0);
        queue_beat(32'd12, 1'b1);
        queue_beat(32'd18, 1'b0);
        queue_beat(32'd36, 1'b0);              // already a multiple
        queue_beat(32'h8000_0000, 1'b0);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'd1, 1'b0);
        queue_beat(32'h5555_5555, 1'b1);
        queue_beat(32'hAAAA_AAAA, 1'b0);
        queue_beat(32'hFFFF_FFFF, 1'b1);
        queue_beat(32'hFFFF_FFFF, 1'b0);       // same period twice
        queue_beat(32'd1, 1'b1);
        queue_beat(32'd1, 1'b0);
        queue_beat(32'h8000_0000, 1'b1);
        queue_beat(32'h4000_0000, 1'b0);

        // Random: mostly well-formed task sets that start with a restart,
        // with random-length content; a few sets run on without one, and a
        // few restarts land in the middle.
        while (period_beats_q.size() < TARGET_BEATS) begin
            set_len = $urandom_range(8, 1);
            for (int i = 0; i < set_len; i++) begin
                restart = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                kind    = $urandom_range(99);
                if (kind < 40) begin
                    queue_beat($urandom_range(100, 1), restart);
                end else if (kind < 65) begin
                    // Products of small primes share factors, so the gcd matters.
                    smooth = 64'd1;
                    repeat ($urandom_range(8, 1)) begin
                        case ($urandom_range(5))
                            0:       factor = 64'd2;
                            1:       factor = 64'd3;
                            2:       factor = 64'd5;
                            3:       factor = 64'd7;
                            4:       factor = 64'd11;
                            default: factor = 64'd13;
                        endcase
                        if (smooth * factor <= 64'hFFFF_FFFF) begin
                            smooth = smooth * factor;
                        end
                    end
                    queue_beat(smooth[31:0], restart);
                end else if (kind < 90) begin
                    queue_beat($urandom, restart);
                end else if (kind < 95) begin
                    queue_beat(32'd0, restart);
                end else begin
                    queue_beat(32'd1 << $urandom_range(31), restart);
                end
            end
        end
        total_beats = period_beats_q.size();

        // Reset once, released at a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every beat sent and every result seen, then let the unit
        // settle to catch any stray output.
        wait (n_in_done == total_beats && hyperperiod_exp_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
